FILE: sv/uer_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_pkg : shared types and constants of the echo ranger
// Beat payloads, register indexes, status and phase codes, reset values.
// ----------------------------------------------------------------------------
package uer_pkg;

   // configuration register indexes
   localparam int unsigned CsrIdxW = 3;
   localparam logic [CsrIdxW-1:0] CsrEnable      = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrTimeout     = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrTrigLow     = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrTrigHigh    = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrMinPulse    = 3'd4;
   localparam logic [CsrIdxW-1:0] CsrMaxPulse    = 3'd5;
   localparam int unsigned CsrDataW = 17;

   localparam int unsigned TickW = 17;
   localparam int unsigned TrigW = 8;
   localparam int unsigned DistW = 12;
   localparam int unsigned StatW = 3;
   localparam int unsigned PhaseW = 3;

   // reset values
   localparam logic [TickW-1:0] TimeoutRst   = 17'd100000;
   localparam logic [TrigW-1:0] TrigLowRst   = 8'd2;
   localparam logic [TrigW-1:0] TrigHighRst  = 8'd10;
   localparam logic [TickW-1:0] MinPulseRst  = 17'd116;
   localparam logic [TickW-1:0] MaxPulseRst  = 17'd23200;
   localparam logic [TickW-1:0] PulseMax     = 17'h1FFFF;

   // distance = pulse * 10 / 58 = pulse * 5 / 29, kept as running quotient
   localparam int unsigned QuotW = 15;
   localparam int unsigned RemW  = 5;
   localparam logic [RemW-1:0] DistStep = 5'd5;
   localparam logic [RemW-1:0] DistDiv  = 5'd29;
   localparam logic [DistW-1:0] DistSat = 12'd4095;

   // status codes
   localparam logic [StatW-1:0] StatusOk          = 3'd0;
   localparam logic [StatW-1:0] StatusRiseTimeout = 3'd1;
   localparam logic [StatW-1:0] StatusFallTimeout = 3'd2;
   localparam logic [StatW-1:0] StatusRange       = 3'd3;
   localparam logic [StatW-1:0] StatusDisabled    = 3'd4;

   // measurement phases
   localparam logic [PhaseW-1:0] PhIdle     = 3'd0;
   localparam logic [PhaseW-1:0] PhTrigLow  = 3'd1;
   localparam logic [PhaseW-1:0] PhTrigHigh = 3'd2;
   localparam logic [PhaseW-1:0] PhWaitRise = 3'd3;
   localparam logic [PhaseW-1:0] PhWaitFall = 3'd4;

   typedef struct packed {
      logic start_req;
      logic echo_level;
   } req_type;

   typedef struct packed {
      logic             trigger_level;
      logic             busy_res;
      logic             done_res;
      logic [StatW-1:0] status;
      logic [DistW-1:0] distance_mm;
   } rsp_type;

endpackage

FILE: sv/ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger : trigger/echo range finder, one beat per tick
// Drives the trigger pulse, times the echo and reports status and distance.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | start_req, echo_level
//  rsp     | out       | rsp_valid/rsp_stall | trigger, busy, done, status, mm
//  csr     | in        | csr_we              | csr_index, csr_wdata
//
//  Every req beat gives exactly one rsp beat, in the next cycle, from a
//  single result register. A req beat is taken in every cycle unless that
//  register holds a beat the sink is stalling, so the rate is one tick per
//  cycle, set by the combinational phase update.
//  Synchronous reset puts the block idle with its configuration and state registers at their defaults.
//  A stall on rsp back-pressures req in the same cycle; nothing is dropped.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  uer_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output uer_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [uer_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [uer_pkg::CsrDataW-1:0]        csr_wdata
);

   // configuration registers
   logic                             enable_ff;
   logic [uer_pkg::TickW-1:0]        timeout_ff;
   logic [uer_pkg::TrigW-1:0]        trig_low_ff;
   logic [uer_pkg::TrigW-1:0]        trig_high_ff;
   logic [uer_pkg::TickW-1:0]        min_pulse_ff;
   logic [uer_pkg::TickW-1:0]        max_pulse_ff;

   // measurement state
   logic [uer_pkg::PhaseW-1:0]       phase_ff,  phase_in;
   logic [uer_pkg::TickW-1:0]        ticks_ff,  ticks_in;
   logic [uer_pkg::TickW-1:0]        pulse_ff,  pulse_in;
   logic [uer_pkg::QuotW-1:0]        quot_ff,   quot_in;
   logic [uer_pkg::RemW-1:0]         rem_ff,    rem_in;
   logic                             trig_ff,   trig_in;

   // result register
   logic                             rsp_valid_ff, rsp_valid_in;
   uer_pkg::rsp_type                 rsp_data_ff,  rsp_data_in;

   logic                             accept;
   logic [uer_pkg::TickW-1:0]        ticks_inc;
   logic [uer_pkg::RemW:0]           rem_sum;
   logic                             done;
   logic [uer_pkg::StatW-1:0]        status;
   logic [uer_pkg::DistW-1:0]        dist_mm;

   // hold req while the result register is full and stalled
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         timeout_ff   <= uer_pkg::TimeoutRst;
         trig_low_ff  <= uer_pkg::TrigLowRst;
         trig_high_ff <= uer_pkg::TrigHighRst;
         min_pulse_ff <= uer_pkg::MinPulseRst;
         max_pulse_ff <= uer_pkg::MaxPulseRst;
      end else if (csr_we) begin
         case (csr_index)
            uer_pkg::CsrEnable:   enable_ff    <= csr_wdata[0];
            uer_pkg::CsrTimeout:  timeout_ff   <= csr_wdata[uer_pkg::TickW-1:0];
            uer_pkg::CsrTrigLow:  trig_low_ff  <= csr_wdata[uer_pkg::TrigW-1:0];
            uer_pkg::CsrTrigHigh: trig_high_ff <= csr_wdata[uer_pkg::TrigW-1:0];
            uer_pkg::CsrMinPulse: min_pulse_ff <= csr_wdata[uer_pkg::TickW-1:0];
            uer_pkg::CsrMaxPulse: max_pulse_ff <= csr_wdata[uer_pkg::TickW-1:0];
            default: ;   // drop writes beyond the register list
         endcase
      end
   end

   assign ticks_inc = ticks_ff + uer_pkg::TickW'(1);
   // running remainder of pulse*5/29, one step per counted pulse tick
   assign rem_sum   = {1'b0, rem_ff} + {1'b0, uer_pkg::DistStep};

   // phase update for one tick
   always_comb begin
      phase_in = phase_ff;
      ticks_in = ticks_ff;
      pulse_in = pulse_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      trig_in  = trig_ff;
      done     = 1'b0;
      status   = uer_pkg::StatusOk;
      dist_mm  = '0;
      case (phase_ff)
         uer_pkg::PhIdle: begin
            if (req_data.start_req) begin
               if (!enable_ff) begin
                  done   = 1'b1;
                  status = uer_pkg::StatusDisabled;
               end else if (trig_low_ff == '0) begin
                  // no low time: trigger rises on the start tick
                  phase_in = uer_pkg::PhTrigHigh;
                  ticks_in = '0;
                  trig_in  = 1'b1;
               end else begin
                  phase_in = uer_pkg::PhTrigLow;
                  ticks_in = '0;
                  trig_in  = 1'b0;
               end
            end
         end
         uer_pkg::PhTrigLow: begin
            ticks_in = ticks_inc;
            if (ticks_inc >= uer_pkg::TickW'(trig_low_ff)) begin
               phase_in = uer_pkg::PhTrigHigh;
               ticks_in = '0;
               trig_in  = 1'b1;
            end
         end
         uer_pkg::PhTrigHigh: begin
            ticks_in = ticks_inc;
            // zero high time behaves as one tick
            if (ticks_inc >= uer_pkg::TickW'(trig_high_ff)) begin
               phase_in = uer_pkg::PhWaitRise;
               ticks_in = '0;
               trig_in  = 1'b0;
            end
         end
         uer_pkg::PhWaitRise: begin
            if (req_data.echo_level) begin
               phase_in = uer_pkg::PhWaitFall;
               ticks_in = '0;
               pulse_in = uer_pkg::TickW'(1);
               quot_in  = '0;
               rem_in   = uer_pkg::DistStep;
            end else if (ticks_ff >= timeout_ff) begin
               phase_in = uer_pkg::PhIdle;
               ticks_in = '0;
               done     = 1'b1;
               status   = uer_pkg::StatusRiseTimeout;
            end else begin
               ticks_in = ticks_inc;
            end
         end
         uer_pkg::PhWaitFall: begin
            if (!req_data.echo_level) begin
               phase_in = uer_pkg::PhIdle;
               ticks_in = '0;
               done     = 1'b1;
               if (pulse_ff < min_pulse_ff || pulse_ff > max_pulse_ff) begin
                  status = uer_pkg::StatusRange;
               end else if (quot_ff > uer_pkg::QuotW'(uer_pkg::DistSat)) begin
                  dist_mm = uer_pkg::DistSat;
               end else begin
                  dist_mm = quot_ff[uer_pkg::DistW-1:0];
               end
            end else if (ticks_ff >= timeout_ff) begin
               phase_in = uer_pkg::PhIdle;
               ticks_in = '0;
               done     = 1'b1;
               status   = uer_pkg::StatusFallTimeout;
            end else begin
               ticks_in = ticks_inc;
               // pulse count saturates; quotient follows it
               if (pulse_ff < uer_pkg::PulseMax) begin
                  pulse_in = pulse_ff + uer_pkg::TickW'(1);
                  if (rem_sum >= {1'b0, uer_pkg::DistDiv}) begin
                     rem_in  = uer_pkg::RemW'(rem_sum - {1'b0, uer_pkg::DistDiv});
                     quot_in = quot_ff + uer_pkg::QuotW'(1);
                  end else begin
                     rem_in  = rem_sum[uer_pkg::RemW-1:0];
                  end
               end
            end
         end
         default: begin
            phase_in = uer_pkg::PhIdle;
            ticks_in = '0;
            trig_in  = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_data_in.trigger_level = trig_in;
      rsp_data_in.busy_res      = (phase_in != uer_pkg::PhIdle);
      rsp_data_in.done_res      = done;
      rsp_data_in.status        = status;
      rsp_data_in.distance_mm   = dist_mm;
   end

   // advance state only on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= uer_pkg::PhIdle;
         ticks_ff <= '0;
         pulse_ff <= '0;
         quot_ff  <= '0;
         rem_ff   <= '0;
         trig_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
         pulse_ff <= pulse_in;
         quot_ff  <= quot_in;
         rem_ff   <= rem_in;
         trig_ff  <= trig_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: sv/uer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_checker : port-level assertions for the echo ranger
// Watches the beat handshakes and result fields over time.
// ----------------------------------------------------------------------------
module uer_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input uer_pkg::rsp_type rsp_data
);

   // an accepted req beat always yields a rsp beat next cycle
   a_req_to_rsp : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted req beat gave no rsp beat");

   // back-pressure only when a result is actually held
   a_stall_src : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req stalled without a held rsp beat");

   // a finished measurement is no longer busy; idle beats carry no result
   a_done_fields : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.done_res ? !rsp_data.busy_res
         : (rsp_data.status == uer_pkg::StatusOk && rsp_data.distance_mm == '0)))
      else $error("inconsistent done, busy and status fields");

   // a stalled rsp beat holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled rsp beat changed");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
